// ===== design/cshd_pkg.sv =====
// Shared types and constants for the checksum header deframer.
// Used by checksum_header_deframer_core and by its checker; no dependencies.
package cshd_pkg;

  // Header geometry.
  localparam int unsigned HDR_BYTES = 6;

  // Configuration register indexes.
  localparam logic [1:0] REG_ADDR_HIGH = 2'd0;
  localparam logic [1:0] REG_ADDR_LOW  = 2'd1;
  localparam logic [1:0] REG_OWN_EN    = 2'd2;

  // Result kinds carried on the output tuser.
  localparam logic [2:0] KIND_HUNT        = 3'd0;
  localparam logic [2:0] KIND_OWN_HDR     = 3'd1;
  localparam logic [2:0] KIND_FWD_HDR     = 3'd2;
  localparam logic [2:0] KIND_DROP_HDR    = 3'd3;
  localparam logic [2:0] KIND_OWN_PAYLOAD = 3'd4;
  localparam logic [2:0] KIND_FWD_PAYLOAD = 3'd5;
  localparam logic [2:0] KIND_DROP_PAYLOAD = 3'd6;

  // One result word.
  typedef struct packed {
    logic [2:0] item_kind;
    logic [7:0] byte_out;
    logic [7:0] packet_position;
    logic [7:0] packet_length;
    logic       last_of_packet;
  } result_t;

endpackage

// ===== design/checksum_header_deframer_core.sv =====
// Checksum header deframer: top level with header search, tagging and output skid.
// Depends on cshd_pkg.

// Byte-serial packet deframer. Each input word carries one received byte and
// a room flag; each produces exactly one output word. While
// hunting, bytes shift through a six-byte header window; a header is found when
// the 8-bit sum of its first five bytes equals the sixth and the length byte is
// nonzero. The header is tagged own, forward or dropped, and the payload words
// that follow are tagged accordingly until the length is reached, with tlast on
// the final word. The block takes one word per cycle while the skid register is empty:
// the whole decision is a short path from the window and the input byte to the result
// register, and a two-entry output stage (result register plus skid register) keeps
// the input open while a finished word waits on the output side. Configuration writes
// are always ready and take effect on the next accepted word.
module checksum_header_deframer_core (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] room_available
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] byte_out, [15:8] packet_position,
                                 // [23:16] packet_length
  output logic [2:0]  m_tuser,   // [2:0] item_kind
  output logic        m_tlast    // last_of_packet
);
  import cshd_pkg::*;

  typedef enum logic [1:0] {
    MODE_HUNT   = 2'd0,
    MODE_ACCEPT = 2'd1,
    MODE_DROP   = 2'd2
  } mode_t;

  // Configuration registers.
  logic [7:0] addr_high;
  logic [7:0] addr_low;
  logic       own_enable;

  // Receive state.
  logic [7:0] window [HDR_BYTES];
  logic [7:0] window_next [HDR_BYTES];
  logic [7:0] position;
  logic [7:0] position_next;
  mode_t      mode;
  mode_t      mode_next;
  logic       destined_here;
  logic       destined_here_next;

  // Output stage.
  result_t    result;
  result_t    out_item;
  result_t    skid_item;
  logic       skid_valid;

  logic       s_accept;
  logic [7:0] rx_byte;
  logic       room;

  // Header search signals.
  logic [7:0] hdr_sum;
  logic [7:0] hdr_len;
  logic       hdr_found;
  logic       hdr_own;
  logic       hdr_accept;
  logic [2:0] hdr_kind;
  logic [7:0] pay_position;
  logic       pay_last;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign s_accept  = s_tvalid && s_tready;
  assign rx_byte   = s_tdata;
  assign room      = s_tuser[0];

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_high  <= 8'd0;
      addr_low   <= 8'd0;
      own_enable <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ADDR_HIGH: addr_high  <= cfg_data;
        REG_ADDR_LOW:  addr_low   <= cfg_data;
        REG_OWN_EN:    own_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Header check on the window as it stands after shifting in the new byte.
  assign hdr_len   = window[1];
  assign hdr_sum   = window[1] + window[2] + window[3] + window[4] + window[5];
  assign hdr_found = (hdr_sum == rx_byte) && (hdr_len != 8'd0);
  assign hdr_own   = (window[4] == addr_high) && (window[5] == addr_low);
  assign hdr_accept = room && (hdr_len >= 8'(HDR_BYTES)) && (!hdr_own || own_enable);
  assign hdr_kind  = hdr_accept ? (hdr_own ? KIND_OWN_HDR : KIND_FWD_HDR) : KIND_DROP_HDR;

  // Payload position saturates at 255.
  assign pay_position = (position == 8'hFF) ? position : position + 8'd1;
  assign pay_last     = pay_position >= window[0];

  // Next state and result for the word being accepted.
  always_comb begin
    window_next        = window;
    position_next      = position;
    mode_next          = mode;
    destined_here_next = destined_here;
    result.byte_out    = rx_byte;
    result.item_kind   = KIND_HUNT;
    result.packet_position = 8'd0;
    result.packet_length   = 8'd0;
    result.last_of_packet  = 1'b0;

    case (mode)
      MODE_HUNT: begin
        for (int i = 0; i < HDR_BYTES - 1; i++) begin
          window_next[i] = window[i + 1];
        end
        window_next[HDR_BYTES - 1] = rx_byte;
        if (hdr_found) begin
          destined_here_next     = hdr_own;
          result.item_kind       = hdr_kind;
          result.packet_position = 8'(HDR_BYTES);
          result.packet_length   = hdr_len;
          if (hdr_len <= 8'(HDR_BYTES)) begin
            // Short packet ends with its header.
            result.last_of_packet = 1'b1;
            for (int i = 0; i < HDR_BYTES; i++) begin
              window_next[i] = 8'd0;
            end
            position_next = 8'd0;
          end else begin
            position_next = 8'(HDR_BYTES);
            mode_next     = hdr_accept ? MODE_ACCEPT : MODE_DROP;
          end
        end
      end
      default: begin
        // Payload: accepting or dropping; the unused code behaves as dropping.
        if (mode == MODE_ACCEPT) begin
          result.item_kind = destined_here ? KIND_OWN_PAYLOAD : KIND_FWD_PAYLOAD;
        end else begin
          result.item_kind = KIND_DROP_PAYLOAD;
        end
        result.packet_position = pay_position;
        result.packet_length   = window[0];
        result.last_of_packet  = pay_last;
        position_next          = pay_position;
        if (pay_last) begin
          for (int i = 0; i < HDR_BYTES; i++) begin
            window_next[i] = 8'd0;
          end
          position_next = 8'd0;
          mode_next     = MODE_HUNT;
        end
      end
    endcase
  end

  // Receive state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HDR_BYTES; i++) begin
        window[i] <= 8'd0;
      end
      position      <= 8'd0;
      mode          <= MODE_HUNT;
      destined_here <= 1'b0;
    end else if (s_accept) begin
      window        <= window_next;
      position      <= position_next;
      mode          <= mode_next;
      destined_here <= destined_here_next;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        out_item   <= skid_item;
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else if (s_accept) begin
        out_item <= result;
        m_tvalid <= 1'b1;
      end else begin
        m_tvalid <= 1'b0;
      end
    end else if (s_accept) begin
      skid_item  <= result;
      skid_valid <= 1'b1;
    end
  end

  assign m_tdata = {out_item.packet_length, out_item.packet_position, out_item.byte_out};
  assign m_tuser = out_item.item_kind;
  assign m_tlast = out_item.last_of_packet;

endmodule

// ===== design/cshd_checker.sv =====
// Port-level checker for checksum_header_deframer_core, with its bind statement.
// Depends on cshd_pkg.
module cshd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);
  import cshd_pkg::*;

  // A stalled output word holds.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // Hunting words carry no position, length or end mark.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_HUNT) |-> (m_tdata[23:8] == 16'd0) && !m_tlast)
    else $error("hunting word with packet fields set");

  // Header words sit at position six with a nonzero length.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_OWN_HDR || m_tuser == KIND_FWD_HDR ||
                 m_tuser == KIND_DROP_HDR)
    |-> (m_tdata[15:8] == 8'(HDR_BYTES)) && (m_tdata[23:16] != 8'd0))
    else $error("header word with bad position or length");

  // Payload words lie past the header and within the length; the end mark
  // comes exactly at the length.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_OWN_PAYLOAD || m_tuser == KIND_FWD_PAYLOAD ||
                 m_tuser == KIND_DROP_PAYLOAD)
    |-> (m_tdata[15:8] > 8'(HDR_BYTES)) && (m_tdata[15:8] <= m_tdata[23:16]) &&
        (m_tlast == (m_tdata[15:8] == m_tdata[23:16])))
    else $error("payload word position out of range");

endmodule

bind checksum_header_deframer_core cshd_checker u_cshd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== dv/deframer_scoreboard_pkg.sv =====
// Scoreboard for the checksum header deframer: predicts each output word
// from the accepted input bytes and the register settings. Depends on cshd_pkg.
`timescale 1ns / 1ps

package deframer_scoreboard_pkg;
  import cshd_pkg::*;

  // Receive state of the deframer.
  typedef enum logic [1:0] {
    RX_HUNT,
    RX_ACCEPT,
    RX_DROP
  } rx_mode_t;

  class deframer_scoreboard;
    // Register copies.
    logic [7:0] node_high;
    logic [7:0] node_low;
    logic       own_enable;

    // Receive state.
    logic [7:0] window [HDR_BYTES];
    logic [7:0] position;
    rx_mode_t   mode;
    logic       here;

    result_t predicted_words [$];
    int mismatches;

    function new();
      node_high = 8'h00;
      node_low = 8'h00;
      own_enable = 1'b1;
      here = 1'b0;
      mismatches = 0;
      clear_packet();
    endfunction

    // End of a packet: empty window, back to hunting.
    function void clear_packet();
      foreach (window[i]) window[i] = 8'h00;
      position = 8'h00;
      mode = RX_HUNT;
    endfunction

    function void write_reg(logic [1:0] index, logic [7:0] data);
      case (index)
        REG_ADDR_HIGH: begin
          node_high = data;
        end
        REG_ADDR_LOW: begin
          node_low = data;
        end
        REG_OWN_EN: begin
          own_enable = data[0];
        end
        default: begin
        end
      endcase
    endfunction

    function int pending();
      return predicted_words.size();
    endfunction

    // Work out the output word caused by one accepted input byte.
    function void note_byte(logic [7:0] value, logic room);
      result_t w;
      logic [7:0] sum;
      logic [7:0] len;
      logic own;
      logic take;
      int i;
      w = '0;
      w.byte_out = value;
      if (mode == RX_HUNT) begin
        for (i = 0; i < HDR_BYTES - 1; i++) window[i] = window[i + 1];
        window[HDR_BYTES - 1] = value;
        sum = window[0] + window[1] + window[2] + window[3] + window[4];
        len = window[0];
        if (sum == window[5] && len != 8'h00) begin
          // Header found: decide own, forward or drop on this byte.
          own = (window[3] == node_high) && (window[4] == node_low);
          take = room && (len >= HDR_BYTES) && (!own || own_enable);
          here = own;
          position = 8'(HDR_BYTES);
          w.item_kind = take ? (own ? KIND_OWN_HDR : KIND_FWD_HDR) : KIND_DROP_HDR;
          w.packet_position = 8'(HDR_BYTES);
          w.packet_length = len;
          if (len <= HDR_BYTES) begin
            // Short packet ends with its header.
            w.last_of_packet = 1'b1;
            clear_packet();
          end else begin
            mode = take ? RX_ACCEPT : RX_DROP;
          end
        end else begin
          w.item_kind = KIND_HUNT;
        end
      end else begin
        // Payload byte; the position saturates at its top value.
        if (position != 8'hFF) position++;
        if (mode == RX_ACCEPT) begin
          w.item_kind = here ? KIND_OWN_PAYLOAD : KIND_FWD_PAYLOAD;
        end else begin
          w.item_kind = KIND_DROP_PAYLOAD;
        end
        w.packet_position = position;
        w.packet_length = window[0];
        w.last_of_packet = (position >= window[0]);
        if (w.last_of_packet) clear_packet();
      end
      predicted_words.push_back(w);
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      mismatches++;
      if (mismatches <= 40) begin
        $display("mismatch on %s: got %h, expected %h", what, got, want);
      end
    endtask

    // Compare one output word with the oldest predicted word.
    task check_word(result_t got);
      result_t want;
      if (predicted_words.size() == 0) begin
        report("word with nothing pending, byte_out", got.byte_out, 8'h00);
        return;
      end
      want = predicted_words.pop_front();
      if (got.item_kind !== want.item_kind) begin
        report("item_kind", {5'd0, got.item_kind}, {5'd0, want.item_kind});
      end
      if (got.byte_out !== want.byte_out) begin
        report("byte_out", got.byte_out, want.byte_out);
      end
      if (got.packet_position !== want.packet_position) begin
        report("packet_position", got.packet_position, want.packet_position);
      end
      if (got.packet_length !== want.packet_length) begin
        report("packet_length", got.packet_length, want.packet_length);
      end
      if (got.last_of_packet !== want.last_of_packet) begin
        report("last_of_packet", {7'd0, got.last_of_packet}, {7'd0, want.last_of_packet});
      end
    endtask
  endclass

endpackage

// ===== dv/tb.sv =====
// Testbench top for checksum_header_deframer_core: drives packets, noise and
// register settings with random idling, and checks every output word.
// Depends on cshd_pkg and deframer_scoreboard_pkg.
`timescale 1ns / 1ps

module tb;
  import cshd_pkg::*;
  import deframer_scoreboard_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_data = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic [0:0]  s_tuser = 1'b0;    // [0] room_available
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // [7:0] byte_out, [15:8] packet_position,
                                  // [23:16] packet_length
  logic [2:0]  m_tuser;           // [2:0] item_kind
  logic        m_tlast;

  deframer_scoreboard sb = new();

  int   sent_items = 0;
  int   quiet_cycles = 0;
  logic hold_off = 1'b0;
  logic steady_tail = 1'b0;
  logic [7:0] node_high = 8'h00;
  logic [7:0] node_low = 8'h00;

  checksum_header_deframer_core u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // All handshakes are observed here, so prediction and checking follow edge order.
  always @(posedge clk) begin : monitor
    result_t seen;
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tuser[0]);
      if (m_tvalid && m_tready) begin
        seen.item_kind = m_tuser;
        seen.byte_out = m_tdata[7:0];
        seen.packet_position = m_tdata[15:8];
        seen.packet_length = m_tdata[23:16];
        seen.last_of_packet = m_tlast;
        sb.check_word(seen);
      end
      // Watchdog: cycles in which no word of any kind moves.
      if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("tb: errors");
          $finish;
        end
      end
    end
  end

  // Output side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_off = 1'b0;
      end else if (!steady_tail && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Offer one byte, with an occasional gap before it, and wait for acceptance.
  task automatic send_byte(input logic [7:0] value, input logic room);
    @(negedge clk);
    if (!steady_tail && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_tdata <= value;
    s_tuser <= room;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_items++;
  endtask

  // Header and payload; room only matters on the checksum byte.
  task automatic send_packet(input logic [7:0] len, input logic [7:0] hi,
                             input logic [7:0] lo, input logic room,
                             input logic bad_sum, input logic cut);
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] check;
    int payload;
    b1 = 8'($urandom_range(0, 255));
    b2 = 8'($urandom_range(0, 255));
    check = len + b1 + b2 + hi + lo;
    if (bad_sum) check = check ^ 8'($urandom_range(1, 255));
    payload = (len > HDR_BYTES) ? int'(len) - HDR_BYTES : 0;
    if (cut && payload > 0) payload = $urandom_range(0, payload - 1);
    send_byte(len, 1'($urandom_range(0, 1)));
    send_byte(b1, 1'($urandom_range(0, 1)));
    send_byte(b2, 1'($urandom_range(0, 1)));
    send_byte(hi, 1'($urandom_range(0, 1)));
    send_byte(lo, 1'($urandom_range(0, 1)));
    send_byte(check, room);
    repeat (payload) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Mostly well-formed packets, some noise, some broken or cut packets.
  task automatic run_traffic(input int count);
    int start;
    int choice;
    int match;
    logic [7:0] len;
    logic [7:0] hi;
    logic [7:0] lo;
    start = sent_items;
    while (sent_items - start < count) begin
      choice = $urandom_range(0, 99);
      match = $urandom_range(0, 3);
      if ($urandom_range(0, 49) == 0) len = 8'($urandom_range(25, 255));
      else len = 8'($urandom_range(0, 24));
      hi = (match <= 2) ? node_high : 8'($urandom_range(0, 255));
      lo = (match <= 1) ? node_low : 8'($urandom_range(0, 255));
      if (choice < 80) begin
        send_packet(len, hi, lo, $urandom_range(0, 4) != 0, 1'b0, 1'b0);
      end else if (choice < 90) begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      end else begin
        send_packet(len, hi, lo, $urandom_range(0, 4) != 0, 1'($urandom_range(0, 1)),
                    1'b1);
      end
    end
  endtask

  // Stop offering and let every pending word drain.
  task automatic settle(input int tail);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] index, input logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] hi, input logic [7:0] lo, input logic own_en);
    cfg_write(REG_ADDR_HIGH, hi);
    cfg_write(REG_ADDR_LOW, lo);
    cfg_write(REG_OWN_EN, {7'd0, own_en});
    @(negedge clk);
    cfg_valid <= 1'b0;
    node_high = hi;
    node_low = lo;
  endtask

  initial begin : stimulus
    wait (!rst);
    // Directed packets under reset settings (address 0, own packets enabled).
    send_packet(8'd3, 8'h12, 8'h34, 1'b1, 1'b0, 1'b0);   // length below six
    send_packet(8'd7, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);   // own, accepted
    send_packet(8'd7, 8'hAB, 8'hCD, 1'b0, 1'b0, 1'b0);   // no room, dropped payload
    send_packet(8'd7, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0);   // forwarded

    settle(4);
    configure(8'hFF, 8'hFF, 1'b0);
    run_traffic(260);

    // The long output hold-off lands in the middle of this phase.
    settle(4);
    configure(8'h00, 8'h00, 1'b1);
    run_traffic(130);
    hold_off = 1'b1;
    run_traffic(130);

    settle(4);
    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
    run_traffic(260);

    settle(4);
    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
    run_traffic(200);

    // Final stretch runs without any idling.
    settle(4);
    steady_tail = 1'b1;
    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
    run_traffic(200);

    settle(8);
    if (sb.mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
